// ===== rtl/core/bba_pkg.sv =====
// Shared types, constants and codes for the buddy block allocator.
// Used by bba_ctrl, bba_dpath and buddy_block_allocator_core.
package bba_pkg;

   // Tree geometry
   localparam int LEAF_COUNT = 1024;
   localparam int LEVELS     = $clog2(LEAF_COUNT + 1) - 1;
   localparam int NODE_COUNT = 2 << LEVELS;
   localparam int NODE_W     = LEVELS + 1;
   localparam int DEPTH_W    = $clog2(LEVELS + 1);
   localparam int LFO_W      = $clog2(LEVELS + 2);
   localparam int EXP_W      = 7;

   // Field widths
   localparam int ADDR_W     = 48;
   localparam int SIZE_W     = 41;
   localparam int BSIZE_W    = 31;
   localparam int SO_W       = 5;
   localparam int MODE_W     = 2;
   localparam int STAT_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = ((SIZE_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + BSIZE_W + 7) / 8) * 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMALLEST_ORDER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE    = 1'b1;
   localparam logic [SO_W-1:0]      SO_RESET           = 5'd12;

   // Request kinds
   localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd4;

   // Node states
   typedef logic [1:0] nstate_type;
   localparam nstate_type NS_UNUSED = 2'd0;
   localparam nstate_type NS_FREE   = 2'd1;
   localparam nstate_type NS_SPLIT  = 2'd2;
   localparam nstate_type NS_ALLOC  = 2'd3;

   // One tree node word: state and largest free order below it
   typedef struct packed {
      nstate_type       st;
      logic [LFO_W-1:0] lfo;
   } node_type;

   // Datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_RD_ROOT,
      OP_TAKE_ROOT,
      OP_RD_KIDS,
      OP_DESCEND,
      OP_WR_SPLIT,
      OP_WR_BUDDY,
      OP_WR_LEAF,
      OP_MARK,
      OP_RD_SIB,
      OP_MERGE_N,
      OP_MERGE_SIB,
      OP_WR_FREE,
      OP_RD_UP,
      OP_UP,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [STAT_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic              clear_done;
      logic [MODE_W-1:0] mode;
      logic              bad_size;
      logic              k_big;
      logic              out_range;
      logic              no_space;
      logic              cur_split;
      logic              need_split;
      logic              found_bad;
      logic              cur_alloc;
      logic              at_root;
      logic              sib_free;
   } flags_type;

endpackage

// ===== rtl/core/bba_dpath.sv =====
// Datapath of the buddy allocator: node memory, walk registers, address math.
// Depends on bba_pkg; driven by bba_ctrl through cmd_type.
module bba_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bba_pkg::cmd_type                    cmd,
   output bba_pkg::flags_type                  flags,
   input  logic [bba_pkg::MODE_W-1:0]          req_mode,
   input  logic [bba_pkg::SIZE_W-1:0]          req_size,
   input  logic [bba_pkg::ADDR_W-1:0]          req_address,
   input  logic                                csr_write,
   input  logic [bba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]          csr_data,
   output logic [bba_pkg::ADDR_W-1:0]          rsp_address,
   output logic [bba_pkg::BSIZE_W-1:0]         rsp_size,
   output logic [bba_pkg::STAT_W-1:0]          rsp_status
);
   import bba_pkg::*;

   node_type             mem [NODE_COUNT];
   node_type             rd_a_ff, rd_b_ff;
   logic [NODE_W-1:0]    ra_a, ra_b, wa;
   node_type             wd;
   logic                 we;

   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [SO_W-1:0]      so_ff, so_in;
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]    off_ff, off_in;
   logic [DEPTH_W-1:0]   k_ff, k_in;
   logic [NODE_W-1:0]    n_ff, n_in;
   logic [DEPTH_W-1:0]   d_ff, d_in;
   nstate_type           cur_st_ff, cur_st_in;
   logic [LFO_W-1:0]     cur_v_ff, cur_v_in;
   logic [ADDR_W-1:0]    mark_addr_ff, mark_addr_in;
   logic [BSIZE_W-1:0]   mark_size_ff, mark_size_in;
   logic [ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [BSIZE_W-1:0]   out_size_ff, out_size_in;
   logic [STAT_W-1:0]    out_stat_ff, out_stat_in;

   logic [5:0]           msb;
   logic                 pow2;
   logic [EXP_W-1:0]     ceil_lg, k_full, e_cur, e_root;
   logic                 go_right;
   logic [NODE_W-1:0]    pos;
   logic [LFO_W-1:0]     up_v, kid_max;

   // Size rounding: position of the top bit and power-of-two test
   always_comb begin
      msb = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (size_ff[i]) msb = 6'(i);
      end
   end
   assign pow2    = (size_ff & (size_ff - SIZE_W'(1))) == '0;
   assign ceil_lg = EXP_W'(msb) + (pow2 ? EXP_W'(0) : EXP_W'(1));
   assign k_full  = ceil_lg - EXP_W'(so_ff);

   // Byte exponent of the current node and of the whole region
   assign e_cur  = EXP_W'(LEVELS) - EXP_W'(d_ff) + EXP_W'(so_ff);
   assign e_root = EXP_W'(LEVELS) + EXP_W'(so_ff);

   // Child choice: lowest fitting subtree, or by address bit
   always_comb begin
      if (mode_ff == MODE_ALLOC) begin
         go_right = rd_a_ff.lfo < (LFO_W'(k_ff) + LFO_W'(1));
      end else begin
         go_right = off_ff[6'(e_cur - EXP_W'(1))];
      end
   end

   assign pos     = n_ff - (NODE_W'(1) << d_ff);
   assign kid_max = (cur_v_ff > rd_b_ff.lfo) ? cur_v_ff : rd_b_ff.lfo;

   // Refreshed value of the parent node
   always_comb begin
      case (rd_a_ff.st)
         NS_FREE:  up_v = LFO_W'(LEVELS) - LFO_W'(d_ff) + LFO_W'(2);
         NS_SPLIT: up_v = kid_max;
         default:  up_v = '0;
      endcase
   end

   // Status back to the controller
   always_comb begin
      flags.clear_done = &clr_ff;
      flags.mode       = mode_ff;
      flags.bad_size   = (size_ff == '0) || ({1'b0, msb} < 7'(so_ff));
      flags.k_big      = k_full > EXP_W'(LEVELS);
      flags.out_range  = (off_ff >> e_root) != '0;
      flags.no_space   = rd_a_ff.lfo < (LFO_W'(k_ff) + LFO_W'(1));
      flags.cur_split  = (cur_st_ff == NS_SPLIT) && (d_ff < DEPTH_W'(LEVELS));
      flags.need_split = (DEPTH_W'(LEVELS) - d_ff) > k_ff;
      flags.found_bad  = !((cur_st_ff == NS_FREE) || (cur_st_ff == NS_ALLOC)) ||
                         ((off_ff & ~({ADDR_W{1'b1}} << e_cur)) != '0);
      flags.cur_alloc  = cur_st_ff == NS_ALLOC;
      flags.at_root    = n_ff == NODE_W'(1);
      flags.sib_free   = rd_b_ff.st == NS_FREE;
   end

   // Operation decode
   always_comb begin
      ra_a         = NODE_W'(1);
      ra_b         = n_ff ^ NODE_W'(1);
      wa           = n_ff;
      wd           = '0;
      we           = 1'b0;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      cur_st_in    = cur_st_ff;
      cur_v_in     = cur_v_ff;
      mark_addr_in = mark_addr_ff;
      mark_size_in = mark_size_ff;
      out_addr_in  = out_addr_ff;
      out_size_in  = out_size_ff;
      out_stat_in  = out_stat_ff;
      case (cmd.op)
         OP_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            wd     = (clr_ff == NODE_W'(1)) ?
                     node_type'{NS_FREE, LFO_W'(LEVELS + 1)} : node_type'('0);
            clr_in = clr_ff + NODE_W'(1);
         end
         OP_LOAD: begin
            mode_in = req_mode;
            size_in = req_size;
            off_in  = req_address - base_ff;
         end
         OP_RD_ROOT: begin
            ra_a = NODE_W'(1);
            k_in = DEPTH_W'(k_full);
         end
         OP_TAKE_ROOT: begin
            n_in      = NODE_W'(1);
            d_in      = '0;
            cur_st_in = rd_a_ff.st;
         end
         OP_RD_KIDS: begin
            ra_a = {n_ff[NODE_W-2:0], 1'b0};
            ra_b = {n_ff[NODE_W-2:0], 1'b1};
         end
         OP_DESCEND: begin
            n_in      = {n_ff[NODE_W-2:0], go_right};
            d_in      = d_ff + DEPTH_W'(1);
            cur_st_in = go_right ? rd_b_ff.st : rd_a_ff.st;
         end
         OP_WR_SPLIT: begin
            we = 1'b1;
            wd = '{NS_SPLIT, '0};
         end
         OP_WR_BUDDY: begin
            we   = 1'b1;
            wa   = {n_ff[NODE_W-2:0], 1'b1};
            wd   = '{NS_FREE, LFO_W'(LEVELS) - LFO_W'(d_ff)};
            n_in = {n_ff[NODE_W-2:0], 1'b0};
            d_in = d_ff + DEPTH_W'(1);
         end
         OP_WR_LEAF: begin
            we           = 1'b1;
            wd           = '{NS_ALLOC, '0};
            cur_v_in     = '0;
            mark_addr_in = base_ff + (ADDR_W'(pos) << e_cur);
            mark_size_in = BSIZE_W'(1) << e_cur;
         end
         OP_MARK: begin
            mark_addr_in = base_ff + (ADDR_W'(pos) << e_cur);
            mark_size_in = BSIZE_W'(1) << e_cur;
         end
         OP_RD_SIB: begin
            ra_b = n_ff ^ NODE_W'(1);
         end
         OP_MERGE_N: begin
            we = 1'b1;
            wd = '0;
         end
         OP_MERGE_SIB: begin
            we   = 1'b1;
            wa   = n_ff ^ NODE_W'(1);
            wd   = '0;
            n_in = n_ff >> 1;
            d_in = d_ff - DEPTH_W'(1);
         end
         OP_WR_FREE: begin
            we       = 1'b1;
            wd       = '{NS_FREE, LFO_W'(LEVELS) - LFO_W'(d_ff) + LFO_W'(1)};
            cur_v_in = LFO_W'(LEVELS) - LFO_W'(d_ff) + LFO_W'(1);
         end
         OP_RD_UP: begin
            ra_a = n_ff >> 1;
            ra_b = n_ff ^ NODE_W'(1);
         end
         OP_UP: begin
            we       = 1'b1;
            wa       = n_ff >> 1;
            wd       = '{rd_a_ff.st, up_v};
            cur_v_in = up_v;
            n_in     = n_ff >> 1;
            d_in     = d_ff - DEPTH_W'(1);
         end
         OP_RESULT: begin
            out_stat_in = cmd.status;
            out_size_in = (cmd.status == ST_OK) ? mark_size_ff : '0;
            out_addr_in = ((cmd.status == ST_OK) && (mode_ff == MODE_ALLOC)) ?
                          mark_addr_ff : '0;
         end
         default: begin
         end
      endcase
   end

   // Configuration registers
   always_comb begin
      so_in   = so_ff;
      base_in = base_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SMALLEST_ORDER: so_in   = csr_data[SO_W-1:0];
            CSR_REGION_BASE:    base_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Node memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_a_ff <= mem[ra_a];
      rd_b_ff <= mem[ra_b];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         so_ff   <= SO_RESET;
         base_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         so_ff   <= so_in;
         base_ff <= base_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      size_ff      <= size_in;
      off_ff       <= off_in;
      k_ff         <= k_in;
      n_ff         <= n_in;
      d_ff         <= d_in;
      cur_st_ff    <= cur_st_in;
      cur_v_ff     <= cur_v_in;
      mark_addr_ff <= mark_addr_in;
      mark_size_ff <= mark_size_in;
      out_addr_ff  <= out_addr_in;
      out_size_ff  <= out_size_in;
      out_stat_ff  <= out_stat_in;
   end

   assign rsp_address = out_addr_ff;
   assign rsp_size    = out_size_ff;
   assign rsp_status  = out_stat_ff;

   // The walk keeps the node number consistent with its depth
   a_descend_depth: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DESCEND) |=> ((n_ff >> d_ff) == NODE_W'(1)))
      else $error("node number does not match depth after descent");

   // Climbing never starts from the root
   a_up_not_root: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_UP || cmd.op == OP_MERGE_SIB) |-> (n_ff != NODE_W'(1) && d_ff != '0))
      else $error("upward step issued at the root");

   // A split only happens above the requested order
   a_split_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_WR_BUDDY) |-> ((DEPTH_W'(LEVELS) - d_ff) > k_ff))
      else $error("split below the requested block order");

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Sequencer of the buddy allocator: clearing pass, tree walks, result handoff.
// Depends on bba_pkg; commands bba_dpath and reads its flags.
module bba_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  bba_pkg::flags_type         flags,
   output bba_pkg::cmd_type           cmd
);
   import bba_pkg::*;

   typedef enum logic [15:0] {
      S_CLEAR  = 16'h0001,
      S_IDLE   = 16'h0002,
      S_CHECK  = 16'h0004,
      S_ROOT   = 16'h0008,
      S_DESC   = 16'h0010,
      S_KIDS   = 16'h0020,
      S_FOUND  = 16'h0040,
      S_SPLIT  = 16'h0080,
      S_BUDDY  = 16'h0100,
      S_LEAF   = 16'h0200,
      S_SIB_RD = 16'h0400,
      S_SIB    = 16'h0800,
      S_MERGE  = 16'h1000,
      S_START  = 16'h2000,
      S_UP     = 16'h4000,
      S_RESULT = 16'h8000
   } state_type;

   state_type         state_ff, state_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              up_pending_ff, up_pending_in;

   // Next state and command
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      up_pending_in = up_pending_ff;
      cmd.op        = OP_NONE;
      cmd.status    = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (flags.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op   = OP_RD_ROOT;
            state_in = S_ROOT;
            if (flags.mode == MODE_ALLOC) begin
               if (flags.bad_size || flags.k_big) begin
                  status_in = ST_BAD_SIZE;
                  state_in  = S_RESULT;
               end
            end else if (flags.mode == MODE_FREE || flags.mode == MODE_LENGTH) begin
               if (flags.out_range) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_RESULT;
               end
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESULT;
            end
         end
         S_ROOT: begin
            cmd.op   = OP_TAKE_ROOT;
            state_in = S_DESC;
            if (flags.mode == MODE_ALLOC && flags.no_space) begin
               status_in = ST_NO_SPACE;
               state_in  = S_RESULT;
            end
         end
         S_DESC: begin
            if (flags.cur_split) begin
               cmd.op   = OP_RD_KIDS;
               state_in = S_KIDS;
            end else begin
               state_in = S_FOUND;
            end
         end
         S_KIDS: begin
            cmd.op   = OP_DESCEND;
            state_in = S_DESC;
         end
         S_FOUND: begin
            if (flags.mode == MODE_ALLOC) begin
               state_in = flags.need_split ? S_SPLIT : S_LEAF;
            end else if (flags.found_bad) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESULT;
            end else if (flags.mode == MODE_LENGTH) begin
               cmd.op    = OP_MARK;
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else if (!flags.cur_alloc) begin
               status_in = ST_NOT_ALLOC;
               state_in  = S_RESULT;
            end else begin
               cmd.op   = OP_MARK;
               state_in = S_SIB_RD;
            end
         end
         S_SPLIT: begin
            cmd.op   = OP_WR_SPLIT;
            state_in = S_BUDDY;
         end
         S_BUDDY: begin
            cmd.op   = OP_WR_BUDDY;
            state_in = S_FOUND;
         end
         S_LEAF: begin
            cmd.op        = OP_WR_LEAF;
            up_pending_in = 1'b0;
            state_in      = S_UP;
         end
         S_SIB_RD: begin
            if (flags.at_root) begin
               state_in = S_START;
            end else begin
               cmd.op   = OP_RD_SIB;
               state_in = S_SIB;
            end
         end
         S_SIB: begin
            if (flags.sib_free) begin
               cmd.op   = OP_MERGE_N;
               state_in = S_MERGE;
            end else begin
               state_in = S_START;
            end
         end
         S_MERGE: begin
            cmd.op   = OP_MERGE_SIB;
            state_in = S_SIB_RD;
         end
         S_START: begin
            cmd.op        = OP_WR_FREE;
            up_pending_in = 1'b0;
            state_in      = S_UP;
         end
         S_UP: begin
            // alternate parent read and parent write up to the root
            if (up_pending_ff) begin
               cmd.op        = OP_UP;
               up_pending_in = 1'b0;
            end else if (flags.at_root) begin
               status_in = ST_OK;
               state_in  = S_RESULT;
            end else begin
               cmd.op        = OP_RD_UP;
               up_pending_in = 1'b1;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         status_ff     <= ST_OK;
         rsp_valid_ff  <= 1'b0;
         up_pending_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         rsp_valid_ff  <= rsp_valid_in;
         up_pending_ff <= up_pending_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A new result only appears after the result state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESULT))
      else $error("response raised outside the result state");

   // No request is taken before the clearing pass ends
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (state_ff == S_CLEAR || state_ff == S_IDLE))
      else $error("clearing pass left early");

   // A parent read is always followed by its write
   a_up_pair: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RD_UP) |=> (cmd.op == OP_UP))
      else $error("parent read without refresh write");

endmodule

// ===== rtl/core/buddy_block_allocator_core.sv =====
// Buddy block allocator over LEAF_COUNT smallest blocks: ports and glue.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
// Usage:
//  - req channel: tuser carries the request kind (allocate, free, length),
//    tdata carries request_size and address. One transaction per request.
//  - rsp channel: exactly one transaction per request, in request order,
//    with status in tuser and result_address / block_size in tdata.
//  - csr channel: register writes (index 0 smallest_order, 1 region_base),
//    always ready; write only while no request is in flight.
//  - A request walks the node tree down through the split nodes; for
//    allocate it then splits at the found node, for free it merges with
//    free buddies, and both refresh each parent back to the root (one
//    node memory read port pair). One request is worked at a time.
//  - After reset all 2*LEAF_COUNT (2048) nodes of the node memory are
//    cleared, one node per cycle; req_tready stays low meanwhile.
//  - A finished result waits in the output register while rsp_tready is low;
//    the next request is still accepted and runs up to its result.
module buddy_block_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // request_size [40:0], address [88:41], zero fill above
   input  logic [bba_pkg::REQ_DATA_W-1:0]      req_tdata,
   // mode [1:0]
   input  logic [bba_pkg::MODE_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_address [47:0], block_size [78:48], zero fill above
   output logic [bba_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status [2:0]
   output logic [bba_pkg::STAT_W-1:0]          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]          csr_data
);
   import bba_pkg::*;

   cmd_type             cmd;
   flags_type           flags;
   logic [ADDR_W-1:0]   rsp_address;
   logic [BSIZE_W-1:0]  rsp_size;

   assign csr_ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   bba_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .flags       (flags),
      .req_mode    (req_tuser),
      .req_size    (req_tdata[SIZE_W-1:0]),
      .req_address (req_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_address (rsp_address),
      .rsp_size    (rsp_size),
      .rsp_status  (rsp_tuser)
   );

   // Pack result fields, lowest field first
   assign rsp_tdata = RSP_DATA_W'({rsp_size, rsp_address});

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for buddy_block_allocator_core: random and directed requests,
// an in-bench tree predictor, and in-order result checking.
// Depends on bba_pkg and the allocator RTL.
module testbench;
   import bba_pkg::*;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] address;
   } alloc_req_type;

   typedef struct {
      logic [ADDR_W-1:0]  addr;
      logic [BSIZE_W-1:0] bsize;
      logic [STAT_W-1:0]  status;
   } alloc_rsp_type;

   localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 10000;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [MODE_W-1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0] rsp_tuser;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0] csr_data;

   buddy_block_allocator_core uut (.*);

   // Predictor state: node tree and register copies
   nstate_type tree_st [0:NODE_COUNT-1];
   int tree_lfo [0:NODE_COUNT-1];
   int cfg_order;
   logic [63:0] cfg_base;
   logic [ADDR_W-1:0] live_blocks[$];

   alloc_req_type request_queue[$];
   alloc_rsp_type expected_results[$];
   alloc_req_type in_flight;
   int send_idle_pct, rsp_stall_pct;
   int hold_requests, hold_served, hold_left;
   int error_count, quiet_cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("testbench: mismatch: %s", msg);
      error_count++;
   endtask

   function automatic logic [63:0] node_bytes(input int d);
      return 64'd1 << (LEVELS - d + cfg_order);
   endfunction

   function automatic logic [63:0] node_offset(input int n, input int d);
      return 64'(n - (1 << d)) << (LEVELS - d + cfg_order);
   endfunction

   function automatic void tree_reset();
      for (int i = 0; i < NODE_COUNT; i++) begin
         tree_st[i] = NS_UNUSED;
         tree_lfo[i] = 0;
      end
      tree_st[1] = NS_FREE;
      tree_lfo[1] = LEVELS + 1;
      cfg_order = SO_RESET;
      cfg_base = 0;
   endfunction

   // Recompute largest free order from n up to the root
   function automatic void refresh_path(input int n);
      int dep, v;
      while (1) begin
         dep = $clog2(n + 1) - 1;
         v = 0;
         if (tree_st[n] == NS_FREE) v = LEVELS - dep + 1;
         else if (tree_st[n] == NS_SPLIT)
            v = (tree_lfo[2*n] > tree_lfo[2*n+1]) ? tree_lfo[2*n] : tree_lfo[2*n+1];
         tree_lfo[n] = v;
         if (n <= 1) break;
         n = n >> 1;
      end
   endfunction

   // Apply one request to the tree and return what the block must answer
   function automatic alloc_rsp_type allocator_step(input alloc_req_type it);
      alloc_rsp_type r;
      logic [63:0] size, off;
      int n, d, k;
      r = '{default: '0};
      n = 1;
      d = 0;
      size = 64'(it.size);
      if (it.mode == MODE_ALLOC) begin
         if (size == 0 || size < (64'd1 << cfg_order)) r.status = ST_BAD_SIZE;
         else begin
            k = 0;
            while (k <= LEVELS && (64'd1 << (k + cfg_order)) < size) k++;
            if (k > LEVELS) r.status = ST_BAD_SIZE;
            else if (tree_lfo[1] < k + 1) r.status = ST_NO_SPACE;
            else begin
               while (tree_st[n] == NS_SPLIT && d < LEVELS) begin
                  n = (tree_lfo[2*n] >= k + 1) ? 2*n : 2*n + 1;
                  d++;
               end
               // split down, keeping the lower half
               while (LEVELS - d > k) begin
                  tree_st[n] = NS_SPLIT;
                  tree_st[2*n] = NS_FREE;
                  tree_st[2*n+1] = NS_FREE;
                  tree_lfo[2*n+1] = LEVELS - d;
                  n = 2*n;
                  d++;
               end
               tree_st[n] = NS_ALLOC;
               refresh_path(n);
               r.addr = ADDR_W'((cfg_base + node_offset(n, d)) & AMASK);
               r.bsize = BSIZE_W'(node_bytes(d));
               live_blocks.push_back(r.addr);
            end
         end
      end else if (it.mode == MODE_FREE || it.mode == MODE_LENGTH) begin
         off = (64'(it.address) - cfg_base) & AMASK;
         if (off >= node_bytes(0)) r.status = ST_NOT_FOUND;
         else begin
            while (tree_st[n] == NS_SPLIT && d < LEVELS) begin
               n = ((off - node_offset(n, d)) >= node_bytes(d + 1)) ? 2*n + 1 : 2*n;
               d++;
            end
            if ((tree_st[n] != NS_FREE && tree_st[n] != NS_ALLOC) || node_offset(n, d) != off)
               r.status = ST_NOT_FOUND;
            else if (it.mode == MODE_LENGTH) r.bsize = BSIZE_W'(node_bytes(d));
            else if (tree_st[n] != NS_ALLOC) r.status = ST_NOT_ALLOC;
            else begin
               r.bsize = BSIZE_W'(node_bytes(d));
               for (int i = 0; i < live_blocks.size(); i++)
                  if (live_blocks[i] == it.address) begin
                     live_blocks.delete(i);
                     break;
                  end
               // merge with the true buddy while it is free
               tree_st[n] = NS_FREE;
               while (n > 1 && tree_st[n ^ 1] == NS_FREE) begin
                  tree_st[n] = NS_UNUSED;
                  tree_st[n ^ 1] = NS_UNUSED;
                  tree_lfo[n] = 0;
                  tree_lfo[n ^ 1] = 0;
                  n = n >> 1;
                  tree_st[n] = NS_FREE;
               end
               refresh_path(n);
            end
         end
      end else r.status = ST_NOT_FOUND;
      return r;
   endfunction

   // Request driver: predict on acceptance, then offer the next pending item
   always @(posedge clock) begin
      if (reset) req_tvalid <= 1'b0;
      else begin
         if (req_tvalid && req_tready) expected_results.push_back(allocator_step(in_flight));
         if (!(req_tvalid && !req_tready)) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight <= request_queue[0];
               req_tuser <= request_queue[0].mode;
               req_tdata <= {{(REQ_DATA_W-ADDR_W-SIZE_W){1'b0}},
                             request_queue[0].address, request_queue[0].size};
               req_tvalid <= 1'b1;
               void'(request_queue.pop_front());
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left <= 400;
         hold_served <= hold_requests;
      end else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Result monitor: backpressure and in-order comparison
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (reset) rsp_tready <= 1'b0;
      else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) report("result with nothing expected");
            else begin
               e = expected_results.pop_front();
               if (rsp_tdata[ADDR_W-1:0] !== e.addr)
                  report($sformatf("address %h, want %h", rsp_tdata[ADDR_W-1:0], e.addr));
               if (rsp_tdata[ADDR_W +: BSIZE_W] !== e.bsize)
                  report($sformatf("size %h, want %h", rsp_tdata[ADDR_W +: BSIZE_W], e.bsize));
               if (rsp_tuser !== e.status)
                  report($sformatf("status %0d, want %0d", rsp_tuser, e.status));
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic push_item(input logic [MODE_W-1:0] mode, input logic [63:0] size,
                            input logic [63:0] address);
      alloc_req_type it;
      it.mode = mode;
      it.size = SIZE_W'(size);
      it.address = ADDR_W'(address);
      while (request_queue.size() >= 4) @(posedge clock);
      request_queue.push_back(it);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SMALLEST_ORDER) cfg_order = value[SO_W-1:0];
      else cfg_base = 64'(value);
   endtask

   // Sender pause: wait for every expected result, then wait further before the next phase
   task automatic drain();
      while (request_queue.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [63:0] noise64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] aligned_address();
      int o;
      logic [63:0] pos;
      o = ($urandom_range(3) == 0) ? $urandom_range(0, LEVELS) : $urandom_range(0, 2);
      pos = $urandom_range(0, (1 << (LEVELS - o)) - 1);
      return (cfg_base + (pos << (o + cfg_order))) & AMASK;
   endfunction

   function automatic logic [63:0] pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 70 && live_blocks.size() > 0)
         return 64'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      else if (r < 95) return aligned_address();
      return noise64();
   endfunction

   task automatic random_phase(input int count);
      int r, o;
      logic [63:0] size;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45) begin
            o = ($urandom_range(9) == 0) ? $urandom_range(0, LEVELS) : $urandom_range(0, 3);
            size = 64'd1 << (o + cfg_order);
            if ($urandom_range(2) == 0) size = size - $urandom_range(0, 32'(size >> 1));
            if ($urandom_range(19) == 0) size = noise64();
            push_item(MODE_ALLOC, size, noise64());
         end else if (r < 80) push_item(MODE_FREE, noise64(), pick_address());
         else if (r < 96) push_item(MODE_LENGTH, noise64(), pick_address());
         else push_item(2'd3, noise64(), pick_address());
      end
   endtask

   task automatic set_phase(input int order, input logic [ADDR_W-1:0] base,
                            input int send_pct, input int stall_pct);
      write_reg(CSR_SMALLEST_ORDER, ADDR_W'(order));
      write_reg(CSR_REGION_BASE, base);
      live_blocks.delete();
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Main sequence
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      error_count = 0;
      quiet_cycles = 0;
      tree_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: size limits, buddies, merges, all kinds, reset settings
      push_item(MODE_ALLOC, 0, 0);
      push_item(MODE_ALLOC, 1, 0);
      push_item(MODE_ALLOC, 4096, 0);
      push_item(MODE_ALLOC, 4097, 0);
      push_item(MODE_ALLOC, 64'd1 << 22, 0);
      push_item(MODE_ALLOC, (64'd1 << 22) + 1, 0);
      push_item(MODE_ALLOC, 64'h1FF_FFFF_FFFF, 0);
      push_item(MODE_LENGTH, 0, 0);
      push_item(MODE_LENGTH, 0, 4096);
      push_item(MODE_FREE, 0, 4096);
      push_item(MODE_FREE, 0, 12345);
      push_item(MODE_FREE, 0, AMASK);
      push_item(MODE_LENGTH, 0, 64'd1 << 22);
      push_item(2'd3, 64'h1FF_FFFF_FFFF, AMASK);
      push_item(MODE_FREE, 0, 0);
      push_item(MODE_FREE, 0, 8192);
      push_item(MODE_LENGTH, 0, 0);
      push_item(MODE_ALLOC, 64'd1 << 22, 0);
      push_item(MODE_ALLOC, 4096, 0);
      push_item(MODE_FREE, 0, 0);
      drain();

      set_phase(12, 0, 0, 0);
      random_phase(205);
      drain();
      set_phase(0, AMASK[ADDR_W-1:0], 47, 0);
      random_phase(205);
      drain();
      // receiver holds off while requests keep coming
      set_phase(20, ADDR_W'(noise64()), 0, 47);
      @(negedge clock) hold_requests++;
      random_phase(205);
      drain();
      set_phase(7, 48'h8000_0000_0000, 25, 25);
      random_phase(205);
      drain();
      set_phase(3, ADDR_W'(noise64()), 0, 0);
      random_phase(205);
      drain();
      set_phase(16, 48'h1234_5678_9ABC, 47, 47);
      random_phase(205);
      drain();

      repeat (100) @(posedge clock);
      if (error_count == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_dpath.sv
rtl/core/bba_ctrl.sv
rtl/core/buddy_block_allocator_core.sv
verif/testbench.sv
